### hdl/osx_pkg.sv
// ----------------------------------------------------------------------------
// osx_pkg
// Shared types and constants of the opaque span extractor.
// ----------------------------------------------------------------------------
package osx_pkg;

    localparam int PIX_W   = 16;
    localparam int KEY_W   = 16;
    localparam int DIM_W   = 11;
    localparam int START_W = 10;
    localparam int END_W   = 11;
    localparam int LEN_W   = 11;
    localparam int CNT_W   = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    typedef struct packed {
        logic               span_valid;
        logic [START_W-1:0] span_start;
        logic [END_W-1:0]   span_end;
        logic [LEN_W-1:0]   span_length;
        logic               row_end;
        logic [CNT_W-1:0]   row_span_count;
        logic               image_end;
    } t_result;

endpackage

### hdl/osx_cfg.sv
// ----------------------------------------------------------------------------
// osx_cfg
// Configuration registers; stores the key and the clamped last column and row.
// ----------------------------------------------------------------------------
module osx_cfg
    import osx_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [KEY_W-1:0]      o_key,
    output logic [COL_W-1:0]      o_last_col,
    output logic [ROW_W-1:0]      o_last_row
);

    localparam int RST_LAST_COL = ((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1;
    localparam int RST_LAST_ROW = ((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024) - 1;

    // A size of zero counts as one and a size above the maximum saturates.
    function automatic int last_index(input logic [DIM_W-1:0] v, input int maxv);
        int vv;
        vv = int'(v);
        if (vv == 0) begin
            return 0;
        end else if (vv > maxv) begin
            return maxv - 1;
        end
        return vv - 1;
    endfunction

    logic [KEY_W-1:0] r_key;
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_last_col <= COL_W'(RST_LAST_COL);
            r_last_row <= ROW_W'(RST_LAST_ROW);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TRANSPARENT_KEY: begin
                    r_key <= i_cfg_data[KEY_W-1:0];
                end
                CFG_ROW_WIDTH: begin
                    r_last_col <= COL_W'(last_index(i_cfg_data[DIM_W-1:0], MAX_WIDTH));
                end
                CFG_IMAGE_HEIGHT: begin
                    r_last_row <= ROW_W'(last_index(i_cfg_data[DIM_W-1:0], MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_key      = r_key;
    assign o_last_col = r_last_col;
    assign o_last_row = r_last_row;

endmodule

### hdl/osx_core.sv
// ----------------------------------------------------------------------------
// osx_core
// Run tracking state and the per-word span and row-end logic.
// ----------------------------------------------------------------------------
module osx_core
    import osx_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [KEY_W-1:0] i_key,
    input  logic [COL_W-1:0] i_last_col,
    input  logic [ROW_W-1:0] i_last_row,
    output t_result          o_result,
    output logic             o_has_result
);

    localparam int CMP_W = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

    logic [COL_W-1:0] r_column;
    logic [ROW_W-1:0] r_row;
    logic             r_prev_t;
    logic [COL_W-1:0] r_run_start;
    logic [CNT_W-1:0] r_span_count;

    logic [COL_W-1:0] n_column;
    logic [ROW_W-1:0] n_row;
    logic             n_prev_t;
    logic [COL_W-1:0] n_run_start;
    logic [CNT_W-1:0] n_span_count;

    logic             transparent;
    logic             last;
    logic             img_end;
    logic             valid;
    logic [COL_W:0]   width;
    logic [COL_W-1:0] s;
    logic [COL_W:0]   e;
    logic [COL_W:0]   len;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        transparent = (i_pixel[CMP_W-1:0] == i_key[CMP_W-1:0]);
        last        = (r_column >= i_last_col);
        img_end     = last && (r_row >= i_last_row);
        width       = {1'b0, i_last_col} + 1'b1;
        valid       = 1'b0;
        s           = '0;
        e           = '0;
        n_run_start = r_run_start;

        if (r_prev_t && !transparent) begin
            if (last) begin
                valid = 1'b1;
                s     = r_column;
                e     = width;
            end else begin
                n_run_start = r_column;
            end
        end else if (!r_prev_t) begin
            if (last) begin
                valid = 1'b1;
                s     = r_run_start;
                e     = width - {{COL_W{1'b0}}, transparent};
            end else if (transparent) begin
                valid = 1'b1;
                s     = r_run_start;
                e     = {1'b0, r_column};
            end
        end

        len     = e - {1'b0, s};
        cnt_inc = (valid && (r_span_count != CNT_MAX)) ? r_span_count + 1'b1 : r_span_count;

        if (last) begin
            n_column     = '0;
            n_row        = img_end ? '0 : r_row + 1'b1;
            n_prev_t     = 1'b1;
            n_run_start  = '0;
            n_span_count = '0;
        end else begin
            n_column     = r_column + 1'b1;
            n_row        = r_row;
            n_prev_t     = transparent;
            n_span_count = cnt_inc;
        end

        o_result.span_valid     = valid;
        o_result.span_start     = START_W'(s);
        o_result.span_end       = END_W'(e);
        o_result.span_length    = LEN_W'(len);
        o_result.row_end        = last;
        o_result.row_span_count = last ? cnt_inc : '0;
        o_result.image_end      = img_end;
        o_has_result            = valid || last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_row        <= '0;
            r_prev_t     <= 1'b1;
            r_run_start  <= '0;
            r_span_count <= '0;
        end else if (i_step) begin
            r_column     <= n_column;
            r_row        <= n_row;
            r_prev_t     <= n_prev_t;
            r_run_start  <= n_run_start;
            r_span_count <= n_span_count;
        end
    end

endmodule

### hdl/opaque_span_extractor.sv
// ----------------------------------------------------------------------------
// opaque_span_extractor
// Finds runs of opaque pixels in a raster stream and reports them as spans.
// ----------------------------------------------------------------------------
// Pixels enter on the slave stream, one word per pixel in raster order. The
// master stream carries one word for each completed span and one for each
// row end; a span that closes on the last pixel of a row shares that word.
// Pixels that neither close a span nor end a row produce no word.
// A word is taken into an input register, processed once the result register
// is empty or being drained, and written to the result register. One pixel
// is accepted every cycle as long as the input register is empty or the
// result register is empty or being drained in the same cycle; the column,
// row and run state is updated when the pixel is processed.
// When the receiver stalls, the result register holds its word and the
// input register fills; after that the slave ready drops until the receiver
// takes the word. Reset clears both registers, returns the counters to the
// first pixel of an image and restores the registers to key 0 and a size of
// 1024 by 1024 (saturated to the maximum size). Configuration writes are
// taken at once and should only be issued while no pixel is in flight.
// ----------------------------------------------------------------------------
module opaque_span_extractor
    import osx_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: pixel.
    input  logic [PIX_W-1:0]      s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: span_start, span_end, span_length, row_span_count.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: span_valid, image_end.
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // Row end.
    output logic                  m_axis_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [KEY_W-1:0] key;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;

    logic             r_in_valid;
    logic [PIX_W-1:0] r_in_pixel;
    logic             r_out_valid;
    t_result          r_out;

    logic             advance;
    logic             step;
    t_result          result;
    logic             has_result;

    osx_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key),
        .o_last_col  (last_col),
        .o_last_row  (last_row)
    );

    osx_core #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_pixel      (r_in_pixel),
        .i_key        (key),
        .i_last_col   (last_col),
        .i_last_row   (last_row),
        .o_result     (result),
        .o_has_result (has_result)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= step && has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_pixel <= s_axis_tdata;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.row_span_count, r_out.span_length,
                            r_out.span_end, r_out.span_start};
    assign m_axis_tuser  = {r_out.image_end, r_out.span_valid};
    assign m_axis_tlast  = r_out.row_end;

    a_word_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.span_valid || r_out.row_end))
        else $error("result word carries neither a span nor a row end");

    a_image_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.image_end |-> r_out.row_end)
        else $error("image end reported away from a row end");

    a_span_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.span_valid && (r_out.span_end >= {1'b0, r_out.span_start})
        |-> (r_out.span_length == r_out.span_end - {1'b0, r_out.span_start}))
        else $error("span length does not match its end and start");

    a_empty_span_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_out.span_valid
        |-> (r_out.span_start == '0 && r_out.span_end == '0 && r_out.span_length == '0))
        else $error("span fields not cleared in a word without a span");

endmodule
